// ----- rtl/dlfb_pkg.sv -----
// shared constants and types for the dense layer forward/backward unit
// used by the front, back and top modules under rtl; no dependencies
package dlfb_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_INPUTS_DEF  = 32;
    localparam int MAX_NEURONS_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 16;

    // fixed point format and field widths
    localparam int FRAC_BITS = 12;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int SUM_W     = 66;
    localparam int FWD_ACC_W = 64;
    localparam int QUEUE_DEPTH = 2;

    // command codes on the input tuser
    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LOAD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_FORWARD     = 2'd2;
    localparam logic [1:0] CMD_BACKWARD    = 2'd3;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_FORWARD = 2'd0;
    localparam logic [1:0] KIND_WGRAD   = 2'd1;
    localparam logic [1:0] KIND_IGRAD   = 2'd2;

    // register map
    localparam logic REG_INPUTS  = 1'b0;
    localparam logic REG_NEURONS = 1'b1;
    localparam logic [CNT_W-1:0] CFG_RESET = 6'd32;

    // control part of one queued item
    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] nr;
        logic [IDX_W-1:0] ip;
        logic             last;
        logic             load_ok;
    } t_ctl;

endpackage

// ----- rtl/dlfb_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module dlfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dlfb_front.sv -----
// front end: accepts stream words, checks load addresses, queues items
// depends on dlfb_pkg
module dlfb_front #(
    parameter int MAX_INPUTS  = dlfb_pkg::MAX_INPUTS_DEF,
    parameter int MAX_NEURONS = dlfb_pkg::MAX_NEURONS_DEF,
    parameter int VALUE_WIDTH = dlfb_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_cmd,
    input  logic [4:0]             i_nr,
    input  logic [4:0]             i_ip,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_last,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output dlfb_pkg::t_ctl         o_q_ctl,
    output logic [VALUE_WIDTH-1:0] o_q_value
);

    localparam int QD  = dlfb_pkg::QUEUE_DEPTH;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW  = $clog2(QD + 1);

    dlfb_pkg::t_ctl         r_ctl [QD];
    logic [VALUE_WIDTH-1:0] r_val [QD];
    logic [PW-1:0]          r_wp, r_rp;
    logic [CW-1:0]          r_cnt;
    dlfb_pkg::t_ctl         w_ctl;
    logic                   w_push;

    // classify the incoming word
    always_comb begin
        w_ctl.cmd     = i_cmd;
        w_ctl.nr      = i_nr;
        w_ctl.ip      = i_ip;
        w_ctl.last    = i_last;
        w_ctl.load_ok = (7'(i_nr) < 7'(MAX_NEURONS)) &&
                        ((i_cmd == dlfb_pkg::CMD_LOAD_BIAS) ||
                         (7'(i_ip) < 7'(MAX_INPUTS)));
    end

    assign o_ready   = (r_cnt != CW'(QD));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_ctl   = r_ctl[r_rp];
    assign o_q_value = r_val[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ctl[r_wp] <= w_ctl;
            r_val[r_wp] <= i_value;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(i_q_pop);
        end
    end

endmodule

// ----- rtl/dlfb_back.sv -----
// back end: sequencer with one multiply-accumulate step and the result register
// depends on dlfb_pkg and dlfb_ram
module dlfb_back #(
    parameter int MAX_INPUTS  = dlfb_pkg::MAX_INPUTS_DEF,
    parameter int MAX_NEURONS = dlfb_pkg::MAX_NEURONS_DEF,
    parameter int VALUE_WIDTH = dlfb_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [5:0]             i_inputs_in_use,
    input  logic [5:0]             i_neurons_in_use,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  dlfb_pkg::t_ctl         i_q_ctl,
    input  logic [VALUE_WIDTH-1:0] i_q_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_kind,
    output logic [4:0]             o_nr,
    output logic [4:0]             o_ip,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_last
);

    localparam int VW   = VALUE_WIDTH;
    localparam int MI   = MAX_INPUTS;
    localparam int MN   = MAX_NEURONS;
    localparam int SW   = dlfb_pkg::SUM_W;
    localparam int FW   = dlfb_pkg::FWD_ACC_W;
    localparam int CW   = dlfb_pkg::CNT_W;
    localparam int FB   = dlfb_pkg::FRAC_BITS;
    localparam int GW   = (2 * VW + 8 > 62) ? 62 : 2 * VW + 8;
    localparam int WD   = MN * MI;
    localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
    localparam int SAW  = (MI > 1) ? $clog2(MI) : 1;
    localparam int BAW  = (MN > 1) ? $clog2(MN) : 1;
    localparam int NCAP = (MN < 32) ? MN : 32;
    localparam logic signed [SW-1:0] FWD_LIM = SW'((65'sd1 <<< 62) - 65'sd1);
    localparam logic signed [SW-1:0] GRD_LIM = SW'((65'sd1 <<< (GW - 1)) - 65'sd1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_FRD  = 4'd2;
    localparam logic [3:0] S_FMUL = 4'd3;
    localparam logic [3:0] S_FACC = 4'd4;
    localparam logic [3:0] S_FOUT = 4'd5;
    localparam logic [3:0] S_BRD  = 4'd6;
    localparam logic [3:0] S_BMUL = 4'd7;
    localparam logic [3:0] S_BACC = 4'd8;
    localparam logic [3:0] S_GRD  = 4'd9;
    localparam logic [3:0] S_GOUT = 4'd10;

    logic [3:0]              r_state, n_state;
    dlfb_pkg::t_ctl          r_ctl;
    logic [VW-1:0]           r_v;
    logic [CW-1:0]           r_n, n_n, r_i, n_i;
    logic signed [FW-1:0]    r_acc, n_acc;
    logic signed [2*VW-1:0]  r_pa, r_pb;
    logic [MI-1:0]           r_gvalid, n_gvalid;
    logic                    r_ovalid, n_ovalid;
    logic [1:0]              r_okind, n_okind;
    logic [4:0]              r_onr, n_onr, r_oip, n_oip;
    logic [VW-1:0]           r_oval, n_oval;
    logic                    r_olast, n_olast;

    logic [CW-1:0]           w_ni, w_nn;
    logic                    w_emit_ok, w_i_end;
    logic [15:0]             w_wlin_wr, w_wlin_rd;
    logic                    w_we_w, w_we_b, w_we_s, w_we_g;
    logic [VW-1:0]           w_rd_w, w_rd_b, w_rd_s;
    logic [GW-1:0]           w_rd_g, w_wd_g;
    logic signed [SW-1:0]    w_fsum, w_gsum, w_gold;

    // saturating add on wide signed values
    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b,
                                                    input logic signed [SW-1:0] lim);
        logic signed [SW-1:0] s;
        s = a + b;
        if (s > lim) begin
            return lim;
        end else if (s < -lim) begin
            return -lim;
        end
        return s;
    endfunction

    // round half up to the value grid and saturate
    function automatic logic [VW-1:0] round_sat(input logic signed [SW-1:0] a);
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] hi, lo;
        hi = SW'((65'sd1 <<< (VW - 1)) - 65'sd1);
        lo = -hi - SW'(1);
        r  = (a + (SW'(1) <<< (FB - 1))) >>> FB;
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return r[VW-1:0];
    endfunction

    // effective sizes from the registers
    always_comb begin
        if (i_inputs_in_use == '0) begin
            w_ni = CW'(1);
        end else if (i_inputs_in_use > CW'(MI)) begin
            w_ni = CW'(MI);
        end else begin
            w_ni = i_inputs_in_use;
        end
        if (i_neurons_in_use == '0) begin
            w_nn = CW'(1);
        end else if (i_neurons_in_use > CW'(NCAP)) begin
            w_nn = CW'(NCAP);
        end else begin
            w_nn = i_neurons_in_use;
        end
    end

    // memory addressing and write strobes
    assign w_wlin_wr = 16'(r_ctl.nr) * 16'(MI) + 16'(r_ctl.ip);
    assign w_wlin_rd = 16'(r_n) * 16'(MI) + 16'(r_i);
    assign w_emit_ok = !r_ovalid || i_ready;
    assign w_i_end   = (r_i == w_ni - CW'(1));
    assign w_we_w    = (r_state == S_EXEC) && (r_ctl.cmd == dlfb_pkg::CMD_LOAD_WEIGHT)
                       && r_ctl.load_ok;
    assign w_we_b    = (r_state == S_EXEC) && (r_ctl.cmd == dlfb_pkg::CMD_LOAD_BIAS)
                       && r_ctl.load_ok;
    assign w_we_s    = (r_state == S_EXEC) && (r_ctl.cmd == dlfb_pkg::CMD_FORWARD)
                       && (CW'(r_ctl.ip) < w_ni);
    assign w_we_g    = (r_state == S_BACC) && w_emit_ok;

    dlfb_ram #(.WIDTH(VW), .DEPTH(WD)) u_weights (
        .i_clk(i_clk), .i_we(w_we_w), .i_waddr(w_wlin_wr[WAW-1:0]), .i_wdata(r_v),
        .i_raddr(w_wlin_rd[WAW-1:0]), .o_rdata(w_rd_w)
    );

    dlfb_ram #(.WIDTH(VW), .DEPTH(MN)) u_bias (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(BAW'(r_ctl.nr)), .i_wdata(r_v),
        .i_raddr(r_n[BAW-1:0]), .o_rdata(w_rd_b)
    );

    dlfb_ram #(.WIDTH(VW), .DEPTH(MI)) u_inputs (
        .i_clk(i_clk), .i_we(w_we_s), .i_waddr(SAW'(r_ctl.ip)), .i_wdata(r_v),
        .i_raddr(r_i[SAW-1:0]), .o_rdata(w_rd_s)
    );

    dlfb_ram #(.WIDTH(GW), .DEPTH(MI)) u_grads (
        .i_clk(i_clk), .i_we(w_we_g), .i_waddr(r_i[SAW-1:0]), .i_wdata(w_wd_g),
        .i_raddr(r_i[SAW-1:0]), .o_rdata(w_rd_g)
    );

    // sums for the forward result and the gradient accumulator
    always_comb begin
        w_fsum = sat_add(SW'(r_acc), SW'(signed'(w_rd_b)) <<< FB, FWD_LIM);
        w_gold = r_gvalid[r_i[SAW-1:0]] ? SW'(signed'(w_rd_g)) : '0;
        w_gsum = sat_add(w_gold, SW'(r_pb), GRD_LIM);
        w_wd_g = w_gsum[GW-1:0];
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_i      = r_i;
        n_acc    = r_acc;
        n_gvalid = r_gvalid;
        n_ovalid = r_ovalid && !i_ready;
        n_okind  = r_okind;
        n_onr    = r_onr;
        n_oip    = r_oip;
        n_oval   = r_oval;
        n_olast  = r_olast;
        o_q_pop  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_i     = '0;
                n_acc   = '0;
                n_state = S_IDLE;
                case (r_ctl.cmd)
                    dlfb_pkg::CMD_FORWARD: begin
                        n_n = '0;
                        if (r_ctl.last) begin
                            n_state = S_FRD;
                        end
                    end
                    dlfb_pkg::CMD_BACKWARD: begin
                        n_n = CW'(r_ctl.nr);
                        if (CW'(r_ctl.nr) < w_nn) begin
                            n_state = S_BRD;
                        end else if (r_ctl.last) begin
                            n_state = S_GRD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FRD: begin
                n_state = S_FMUL;
            end
            S_FMUL: begin
                n_state = S_FACC;
            end
            S_FACC: begin
                n_acc = FW'(sat_add(SW'(r_acc), SW'(r_pa), FWD_LIM));
                if (w_i_end) begin
                    n_state = S_FOUT;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_FRD;
                end
            end
            S_FOUT: begin
                if (w_emit_ok) begin
                    n_ovalid = 1'b1;
                    n_okind  = dlfb_pkg::KIND_FORWARD;
                    n_onr    = r_n[4:0];
                    n_oip    = '0;
                    n_oval   = round_sat(w_fsum);
                    n_olast  = (r_n == w_nn - CW'(1));
                    n_i      = '0;
                    n_acc    = '0;
                    if (r_n == w_nn - CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_n     = r_n + CW'(1);
                        n_state = S_FRD;
                    end
                end
            end
            S_BRD: begin
                n_state = S_BMUL;
            end
            S_BMUL: begin
                n_state = S_BACC;
            end
            S_BACC: begin
                if (w_emit_ok) begin
                    n_ovalid = 1'b1;
                    n_okind  = dlfb_pkg::KIND_WGRAD;
                    n_onr    = r_n[4:0];
                    n_oip    = r_i[4:0];
                    n_oval   = round_sat(SW'(r_pa));
                    n_olast  = w_i_end && !r_ctl.last;
                    n_gvalid[r_i[SAW-1:0]] = 1'b1;
                    if (w_i_end) begin
                        n_i     = '0;
                        n_state = r_ctl.last ? S_GRD : S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_BRD;
                    end
                end
            end
            S_GRD: begin
                n_state = S_GOUT;
            end
            S_GOUT: begin
                if (w_emit_ok) begin
                    n_ovalid = 1'b1;
                    n_okind  = dlfb_pkg::KIND_IGRAD;
                    n_onr    = '0;
                    n_oip    = r_i[4:0];
                    n_oval   = round_sat(w_gold);
                    n_olast  = w_i_end;
                    n_gvalid[r_i[SAW-1:0]] = 1'b0;
                    if (w_i_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_GRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gvalid <= n_gvalid;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers and products
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ctl <= i_q_ctl;
            r_v   <= i_q_value;
        end
        if (r_state == S_FMUL) begin
            r_pa <= signed'(w_rd_s) * signed'(w_rd_w);
        end
        if (r_state == S_BMUL) begin
            r_pa <= signed'(w_rd_s) * signed'(r_v);
            r_pb <= signed'(r_v) * signed'(w_rd_w);
        end
        r_n     <= n_n;
        r_i     <= n_i;
        r_acc   <= n_acc;
        r_okind <= n_okind;
        r_onr   <= n_onr;
        r_oip   <= n_oip;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign o_valid = r_ovalid;
    assign o_kind  = r_okind;
    assign o_nr    = r_onr;
    assign o_ip    = r_oip;
    assign o_value = r_oval;
    assign o_last  = r_olast;

endmodule

// ----- rtl/dense_layer_forward_backward_unit.sv -----
// top level of the dense layer unit: stream ports, apb registers, front and back
// depends on dlfb_pkg, dlfb_front, dlfb_back
//
// channel   direction  handshake           payload
// s stream  in         tvalid/tready       tuser cmd, tdata nr/ip/value, tlast
// m stream  out        tvalid/tready       tuser kind, tdata nr/ip/value, tlast
// apb       in/out     psel/penable/pready inputs_in_use at 0, neurons_in_use at 4
//
// a load passes the exec state; a forward pass runs read, multiply and accumulate
// per input and an output step per neuron; a gradient runs read, multiply and
// accumulate per input, then read and output per input for the input gradients.
// a 2-entry queue takes items while the back end works; the output register stalls
// the sequencer only while a result waits. reset is synchronous, active low.
module dense_layer_forward_backward_unit #(
    parameter int MAX_INPUTS  = dlfb_pkg::MAX_INPUTS_DEF,
    parameter int MAX_NEURONS = dlfb_pkg::MAX_NEURONS_DEF,
    parameter int VALUE_WIDTH = dlfb_pkg::VALUE_WIDTH_DEF,
    localparam int DW = ((10 + VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [DW-1:0] i_s_tdata,   // neuron_index, input_index, value, zero pad
    input  logic [1:0]    i_s_tuser,   // cmd
    input  logic          i_s_tlast,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [DW-1:0] o_m_tdata,   // neuron_index_res, input_index_res, value_res, pad
    output logic [1:0]    o_m_tuser,   // kind
    output logic          o_m_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int VW = VALUE_WIDTH;

    logic [5:0]      r_inputs_in_use, r_neurons_in_use;
    logic            w_q_valid, w_q_pop;
    dlfb_pkg::t_ctl  w_q_ctl;
    logic [VW-1:0]   w_q_value, w_m_value;
    logic [4:0]      w_m_nr, w_m_ip;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_in_use  <= dlfb_pkg::CFG_RESET;
            r_neurons_in_use <= dlfb_pkg::CFG_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == dlfb_pkg::REG_INPUTS) begin
                r_inputs_in_use <= pwdata[5:0];
            end else begin
                r_neurons_in_use <= pwdata[5:0];
            end
        end
    end

    assign prdata = (paddr[2] == dlfb_pkg::REG_NEURONS) ? 32'(r_neurons_in_use)
                                                        : 32'(r_inputs_in_use);

    dlfb_front #(.MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS),
                 .VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_cmd(i_s_tuser), .i_nr(i_s_tdata[4:0]), .i_ip(i_s_tdata[9:5]),
        .i_value(i_s_tdata[VW+9:10]), .i_last(i_s_tlast),
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_ctl(w_q_ctl), .o_q_value(w_q_value)
    );

    dlfb_back #(.MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS),
                .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_inputs_in_use(r_inputs_in_use), .i_neurons_in_use(r_neurons_in_use),
        .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_ctl(w_q_ctl), .i_q_value(w_q_value),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready), .o_kind(o_m_tuser),
        .o_nr(w_m_nr), .o_ip(w_m_ip), .o_value(w_m_value), .o_last(o_m_tlast)
    );

    // pack the result word
    assign o_m_tdata = DW'({w_m_value, w_m_ip, w_m_nr});

endmodule

// ----- bench/dense_layer_forward_backward_checker.sv -----
// result checker for the dense layer unit: predicts every result word and compares
// depends on dlfb_pkg for the command and kind codes
`timescale 1ns / 1ps

module dense_layer_forward_backward_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // neuron_index, input_index, value, zero pad
    input  logic [1:0]  i_s_tuser,   // cmd
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // neuron_index_res, input_index_res, value_res, pad
    input  logic [1:0]  i_m_tuser,   // kind
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] ADDR_INPUTS  = 3'd0;
    localparam logic [2:0] ADDR_NEURONS = 3'd4;
    localparam longint FWD_LIM  = 64'sh3fff_ffff_ffff_ffff;
    localparam longint GRAD_LIM = 64'sh0000_007f_ffff_ffff;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  nr;
        logic [4:0]  ip;
        logic [15:0] val;
        logic        last;
    } t_layer_word;

    t_layer_word expected_words[$];

    logic signed [15:0] weights [32][32];
    logic signed [15:0] biases [32];
    logic signed [15:0] saved_x [32];
    longint             grad_acc [32];
    logic [5:0]         inputs_reg;
    logic [5:0]         neurons_reg;

    assign o_pending = expected_words.size();

    function automatic int clamp_count(logic [5:0] r);
        if (r < 1) return 1;
        if (r > 32) return 32;
        return int'(r);
    endfunction

    function automatic longint sat_add(longint a, longint b, longint lim);
        if (b > 0 && a > lim - b) return lim;
        if (b < 0 && a < -lim - b) return -lim;
        return a + b;
    endfunction

    // round half up to 12 fraction bits, then saturate to 16 bits
    function automatic logic [15:0] round_sat(longint acc);
        longint r;
        r = (acc + 64'sd2048) >>> 12;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic void push_word(logic [1:0] kind, int nr, int ip, logic [15:0] val);
        t_layer_word w;
        w.kind = kind;
        w.nr   = nr[4:0];
        w.ip   = ip[4:0];
        w.val  = val;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    // work out the result words that one accepted input word causes
    function automatic void predict_layer(logic [1:0] cmd, logic [4:0] nr, logic [4:0] ip,
                                          logic signed [15:0] v, logic last);
        int ni;
        int nn;
        int before_cnt;
        longint acc;
        ni = clamp_count(inputs_reg);
        nn = clamp_count(neurons_reg);
        before_cnt = expected_words.size();
        case (cmd)
            dlfb_pkg::CMD_LOAD_WEIGHT: weights[nr][ip] = v;
            dlfb_pkg::CMD_LOAD_BIAS:   biases[nr] = v;
            dlfb_pkg::CMD_FORWARD: begin
                if (ip < ni) saved_x[ip] = v;
                if (last) begin
                    for (int n = 0; n < nn; n++) begin
                        acc = 0;
                        for (int i = 0; i < ni; i++)
                            acc = sat_add(acc, longint'(saved_x[i]) * longint'(weights[n][i]),
                                          FWD_LIM);
                        acc = sat_add(acc, longint'(biases[n]) <<< 12, FWD_LIM);
                        push_word(dlfb_pkg::KIND_FORWARD, n, 0, round_sat(acc));
                    end
                end
            end
            default: begin
                if (nr < nn) begin
                    for (int i = 0; i < ni; i++) begin
                        push_word(dlfb_pkg::KIND_WGRAD, nr, i,
                                  round_sat(longint'(saved_x[i]) * longint'(v)));
                        grad_acc[i] = sat_add(grad_acc[i],
                                              longint'(v) * longint'(weights[nr][i]), GRAD_LIM);
                    end
                end
                if (last) begin
                    for (int i = 0; i < ni; i++) begin
                        push_word(dlfb_pkg::KIND_IGRAD, 0, i, round_sat(grad_acc[i]));
                        grad_acc[i] = 0;
                    end
                end
            end
        endcase
        if (expected_words.size() > before_cnt)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    // watch the channels and the register port
    always @(posedge i_clk) begin
        t_layer_word w;
        if (!i_rst_n) begin
            inputs_reg  <= 6'd32;
            neurons_reg <= 6'd32;
            for (int i = 0; i < 32; i++) grad_acc[i] = 0;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_INPUTS) inputs_reg <= i_pwdata[5:0];
                else if (i_paddr == ADDR_NEURONS) neurons_reg <= i_pwdata[5:0];
            end
            if (i_s_tvalid && i_s_tready)
                predict_layer(i_s_tuser, i_s_tdata[4:0], i_s_tdata[9:5], i_s_tdata[25:10],
                              i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word kind %0d tdata %h", i_m_tuser,
                                 i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = expected_words.pop_front();
                    if (w.kind !== i_m_tuser || w.nr !== i_m_tdata[4:0] ||
                        w.ip !== i_m_tdata[9:5] || w.val !== i_m_tdata[25:10] ||
                        w.last !== i_m_tlast || i_m_tdata[31:26] !== 6'd0) begin
                        if (o_fail_count < 10)
                            $display({"mismatch exp kind %0d nr %0d ip %0d val %h last %0d,",
                                      " got kind %0d nr %0d ip %0d val %h last %0d"},
                                     w.kind, w.nr, w.ip, w.val, w.last, i_m_tuser,
                                     i_m_tdata[4:0], i_m_tdata[9:5], i_m_tdata[25:10],
                                     i_m_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/dense_layer_forward_backward_unit_tb.sv -----
// testbench top for the dense layer unit: clock, reset, stimulus and verdict
// depends on dlfb_pkg, the unit under rtl and dense_layer_forward_backward_checker
`timescale 1ns / 1ps

module dense_layer_forward_backward_unit_tb;

    localparam logic [2:0] ADDR_INPUTS  = 3'd0;
    localparam logic [2:0] ADDR_NEURONS = 3'd4;
    localparam int DRAIN_CYCLES = 4000;
    localparam int STALL_LIMIT  = 50000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_words;
    int gap_pct = 0;
    int stall_pct = 0;
    int word_count = 0;
    int quiet_cycles = 0;
    int num_in = 32;
    int num_nr = 32;
    bit weight_set [32][32];
    bit bias_set [32];
    bit x_set [32];

    dense_layer_forward_backward_unit dut (.*);

    dense_layer_forward_backward_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending_words)
    );

    always #1 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) i_m_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("dense_layer_forward_backward_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(8191) - 4096);
        endcase
    endfunction

    // one input word, held until the unit takes it
    task automatic send_word(logic [1:0] cmd, int nr, int ip, logic [15:0] v, logic last);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'd0, v, 5'(ip), 5'(nr)};
        i_s_tlast  <= last;
        if (cmd == dlfb_pkg::CMD_LOAD_WEIGHT) weight_set[nr][ip] = 1'b1;
        if (cmd == dlfb_pkg::CMD_LOAD_BIAS) bias_set[nr] = 1'b1;
        if (cmd == dlfb_pkg::CMD_FORWARD && ip < num_in) x_set[ip] = 1'b1;
        word_count++;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // load every store entry that the current sizes may read
    task automatic fill_missing();
        for (int n = 0; n < num_nr; n++) begin
            for (int i = 0; i < num_in; i++)
                if (!weight_set[n][i])
                    send_word(dlfb_pkg::CMD_LOAD_WEIGHT, n, i, pick_value(), 1'b0);
            if (!bias_set[n]) send_word(dlfb_pkg::CMD_LOAD_BIAS, n, 0, pick_value(), 1'b0);
        end
        for (int i = 0; i < num_in; i++)
            if (!x_set[i]) send_word(dlfb_pkg::CMD_FORWARD, 0, i, pick_value(), 1'b0);
    endtask

    // setup and access phases, then psel is dropped and the bus idles
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // new sizes, only once the unit is idle
    task automatic set_sizes(logic [5:0] raw_in, logic [5:0] raw_nr);
        wait_drained();
        apb_write(ADDR_INPUTS, {26'd0, raw_in});
        apb_write(ADDR_NEURONS, {26'd0, raw_nr});
        num_in = (raw_in < 1) ? 1 : (raw_in > 32) ? 32 : raw_in;
        num_nr = (raw_nr < 1) ? 1 : (raw_nr > 32) ? 32 : raw_nr;
        fill_missing();
    endtask

    task automatic random_traffic(int target);
        int r;
        int cnt;
        while (word_count < target) begin
            r = $urandom_range(99);
            if (r < 40) begin
                // forward frame
                for (int i = 0; i < num_in; i++)
                    send_word(dlfb_pkg::CMD_FORWARD, $urandom_range(31), i, pick_value(),
                              i == num_in - 1);
            end else if (r < 80) begin
                // gradient run
                cnt = $urandom_range(1, 3);
                for (int g = 0; g < cnt; g++)
                    send_word(dlfb_pkg::CMD_BACKWARD, $urandom_range(num_nr - 1),
                              $urandom_range(31), pick_value(), g == cnt - 1);
            end else if (r < 88) begin
                send_word(dlfb_pkg::CMD_LOAD_WEIGHT, $urandom_range(31), $urandom_range(31),
                          pick_value(), $urandom_range(1));
            end else if (r < 92) begin
                send_word(dlfb_pkg::CMD_LOAD_BIAS, $urandom_range(31), $urandom_range(31),
                          pick_value(), $urandom_range(1));
            end else if (r < 96) begin
                send_word(dlfb_pkg::CMD_FORWARD, $urandom_range(31), $urandom_range(31),
                          pick_value(), 1'b0);
            end else begin
                // gradient for a neuron outside the used range, or neuron 31 when all 32 are used
                send_word(dlfb_pkg::CMD_BACKWARD,
                          (num_nr < 32) ? $urandom_range(31, num_nr) : 31,
                          $urandom_range(31), pick_value(), $urandom_range(1));
            end
        end
    endtask

    // stimulus
    initial begin
        logic [5:0] cfg_in [8] = '{6'd1, 6'd32, 6'd1, 6'd63, 6'd0, 6'd6, 6'd3, 6'd8};
        logic [5:0] cfg_nr [8] = '{6'd1, 6'd1, 6'd32, 6'd2, 6'd5, 6'd4, 6'd9, 6'd8};
        int gap_modes [4]   = '{0, 75, 0, 34};
        int stall_modes [4] = '{0, 0, 75, 34};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small layer, extreme values and the special cases
        set_sizes(6'd4, 6'd3);
        send_word(dlfb_pkg::CMD_LOAD_WEIGHT, 0, 0, 16'h7fff, 1'b0);
        send_word(dlfb_pkg::CMD_LOAD_WEIGHT, 0, 1, 16'h7fff, 1'b0);
        send_word(dlfb_pkg::CMD_LOAD_WEIGHT, 1, 0, 16'h8000, 1'b0);
        send_word(dlfb_pkg::CMD_LOAD_BIAS, 2, 0, 16'h8000, 1'b0);
        send_word(dlfb_pkg::CMD_LOAD_BIAS, 0, 0, 16'h7fff, 1'b0);
        send_word(dlfb_pkg::CMD_FORWARD, 0, 0, 16'h7fff, 1'b0);
        send_word(dlfb_pkg::CMD_FORWARD, 0, 1, 16'h7fff, 1'b0);
        send_word(dlfb_pkg::CMD_FORWARD, 0, 2, 16'h8000, 1'b0);
        // out of range, pass still runs
        send_word(dlfb_pkg::CMD_FORWARD, 31, 31, 16'h1234, 1'b1);
        send_word(dlfb_pkg::CMD_FORWARD, 0, 3, 16'h0001, 1'b1);
        send_word(dlfb_pkg::CMD_BACKWARD, 0, 0, 16'h7fff, 1'b0);
        send_word(dlfb_pkg::CMD_BACKWARD, 1, 0, 16'h8000, 1'b0);
        send_word(dlfb_pkg::CMD_BACKWARD, 2, 0, 16'h0800, 1'b1);
        // no neuron, only input gradients
        send_word(dlfb_pkg::CMD_BACKWARD, 31, 31, 16'h7fff, 1'b1);
        send_word(dlfb_pkg::CMD_BACKWARD, 0, 0, 16'h8000, 1'b0);
        send_word(dlfb_pkg::CMD_BACKWARD, 0, 0, 16'h8000, 1'b1);
        send_word(dlfb_pkg::CMD_FORWARD, 0, 0, 16'h0000, 1'b1);

        // random phases over sizes and idling modes
        for (int p = 0; p < 8; p++) begin
            set_sizes(cfg_in[p], cfg_nr[p]);
            gap_pct   = gap_modes[p % 4];
            stall_pct = stall_modes[p % 4];
            random_traffic(word_count + 20);
        end
        gap_pct   = 0;
        stall_pct = 0;
        wait_drained();

        if (fail_count == 0 && pending_words == 0)
            $display("dense_layer_forward_backward_unit regression: pass");
        else
            $display("dense_layer_forward_backward_unit regression: fail");
        $finish;
    end

endmodule
